FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define MPR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define MPR_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MPR_ASSERT(lbl, clk, rst, prop, msg)
`define MPR_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

FILE: rtl/mpr_pkg.sv
// ----------------------------------------------------------------------------
// MCTP reassembly package
// Word types, status codes, register indexes and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mpr_pkg;

  // Message buffer size in bytes
  localparam int unsigned MaxMsg = 1024;
  // Width of lengths and offsets before masking (holds MaxMsg plus one packet)
  localparam int unsigned LenW = 11;
  localparam int unsigned OffW = 10;

  // Register indexes (byte address bit 2)
  localparam logic RegLocalEid = 1'b0;
  localparam logic RegSeqCheck = 1'b1;

  typedef enum logic [2:0] {
    StAccepted  = 3'd0,
    StComplete  = 3'd1,
    StTooSmall  = 3'd2,
    StBadDest   = 3'd3,
    StBadSeq    = 3'd4,
    StOverflow  = 3'd5,
    StTooLong   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       pkt_last;
  } pkt_word_t;

  typedef struct packed {
    logic            wr_en;
    logic [OffW-1:0] wr_offset;
    logic [7:0]      wr_byte;
    logic            pkt_end;
    status_t         status;
    logic [6:0]      msg_kind;
    logic            msg_ic;
    logic [7:0]      src_eid;
    logic [2:0]      msg_tag;
    logic            tag_owner;
    logic [LenW-1:0] msg_len;
  } msg_word_t;

endpackage

`default_nettype wire

FILE: rtl/mctp_packet_reassembly_unit.sv
// ----------------------------------------------------------------------------
// MCTP packet reassembly unit
// Takes a received MCTP packet one byte per word, checks the transport
// header, emits payload bytes as buffer writes and reports per-packet status.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              word
//  --------  ---  ---------------------  ---------------------------------
//  pkt       in   pkt_valid / pkt_stall  mpr_pkg::pkt_word_t (byte, last)
//  msg       out  msg_valid / msg_stall  mpr_pkg::msg_word_t (write, status)
//  cfg       in   APB psel/penable       local_eid @0x0, seq_check_enable @0x4
//
//  One word per cycle sustained while msg is not stalled; from acceptance
//  the result word passes the input register, then the result register.
//  All packet state is updated when the input register hands off to the
//  result register, so results follow input order exactly.
//  rst (synchronous) clears packet state, valid flags and configuration registers.
//  A stalled result blocks the input register, which then stalls pkt.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mctp_packet_reassembly_unit (
  input  wire               clk,
  input  wire               rst,
  // packet bytes
  input  wire               pkt_valid,
  output logic              pkt_stall,
  input  wire mpr_pkg::pkt_word_t pkt_word,
  // results
  output logic              msg_valid,
  input  wire               msg_stall,
  output mpr_pkg::msg_word_t msg_word,
  // configuration
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned LenW = mpr_pkg::LenW;

  // configuration registers
  logic [7:0] local_eid;
  logic       seq_check_enable;

  // input register
  logic               stage_valid;
  mpr_pkg::pkt_word_t stage_word;
  logic               advance;

  // packet state
  logic [7:0]      byte_position, byte_position_next;
  logic [7:0]      hdr_dest, hdr_dest_next;
  logic [7:0]      hdr_source, hdr_source_next;
  logic [7:0]      hdr_flags, hdr_flags_next;
  logic [7:0]      pending_type_byte, pending_type_byte_next;
  logic [LenW-1:0] committed_length, committed_length_next;
  logic [1:0]      last_seq, last_seq_next;
  logic [6:0]      saved_type, saved_type_next;
  logic            saved_ic, saved_ic_next;
  logic [7:0]      saved_source, saved_source_next;
  logic [3:0]      saved_tag_and_owner, saved_tag_and_owner_next;

  mpr_pkg::msg_word_t res_next;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_eid        <= '0;
      seq_check_enable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        mpr_pkg::RegLocalEid: local_eid        <= pwdata[7:0];
        mpr_pkg::RegSeqCheck: seq_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mpr_pkg::RegLocalEid: prdata = {24'd0, local_eid};
      mpr_pkg::RegSeqCheck: prdata = {31'd0, seq_check_enable};
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ handshakes
  // The input register moves on when the result register is empty or drains.
  assign advance   = stage_valid && (!msg_valid || !msg_stall);
  assign pkt_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pkt_valid && !pkt_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && !pkt_stall) begin
      stage_word <= pkt_word;
    end
  end

  // ---------------------------------------------------------- packet logic
  always_comb begin
    logic [7:0]      idx;
    logic [7:0]      b;
    logic            last;
    logic            too_long;
    logic            som;
    logic            eom;
    logic [1:0]      seq;
    logic            dest_ok;
    logic            seq_ok;
    logic [LenW-1:0] base;
    logic [LenW-1:0] off;
    logic [LenW-1:0] plen;
    logic [LenW-1:0] total;
    logic [7:0]      type_byte;

    idx      = byte_position;
    b        = stage_word.rx_byte;
    last     = stage_word.pkt_last;
    // byte_position saturates at 255, so the 256th and later bytes sit there
    too_long = (idx == 8'd255);
    som      = hdr_flags[7];
    eom      = hdr_flags[6];
    seq      = hdr_flags[5:4];
    dest_ok  = (hdr_dest == 8'hFF) || (hdr_dest == 8'h00) || (hdr_dest == local_eid);
    seq_ok   = som ? !(seq_check_enable && (seq != 2'd0))
                   : ((last_seq + 2'd1) == seq);
    base     = som ? '0 : committed_length;
    // payload offset within the message; only meaningful once idx >= 4
    off      = base + LenW'(idx) - LenW'(4) - LenW'(som);
    plen     = LenW'(idx) - LenW'(3) - LenW'(som);
    total    = base + plen;
    // a five-byte start packet ends on its message header byte
    type_byte = (idx == 8'd4 && som) ? b : pending_type_byte;

    byte_position_next       = byte_position;
    hdr_dest_next            = hdr_dest;
    hdr_source_next          = hdr_source;
    hdr_flags_next           = hdr_flags;
    pending_type_byte_next   = pending_type_byte;
    committed_length_next    = committed_length;
    last_seq_next            = last_seq;
    saved_type_next          = saved_type;
    saved_ic_next            = saved_ic;
    saved_source_next        = saved_source;
    saved_tag_and_owner_next = saved_tag_and_owner;
    res_next                 = '0;

    // header capture
    if (!too_long) begin
      byte_position_next = idx + 8'd1;
      case (idx)
        8'd1: hdr_dest_next   = b;
        8'd2: hdr_source_next = b;
        8'd3: hdr_flags_next  = b;
        8'd4: if (som) pending_type_byte_next = b;
        default: ;
      endcase
    end

    // payload write, dropped early on a known bad header or beyond the buffer
    if (!too_long && idx >= 8'd4 && !(som && idx == 8'd4) && dest_ok && seq_ok &&
        off < LenW'(mpr_pkg::MaxMsg)) begin
      res_next.wr_en     = 1'b1;
      res_next.wr_offset = off[mpr_pkg::OffW-1:0];
      res_next.wr_byte   = b;
    end

    // packet end: checks and commit
    if (last) begin
      byte_position_next = '0;
      res_next.pkt_end   = 1'b1;
      if (too_long) begin
        res_next.status = mpr_pkg::StTooLong;
      end else if (idx <= 8'd3) begin
        res_next.status = mpr_pkg::StTooSmall;
      end else if (!dest_ok) begin
        res_next.status = mpr_pkg::StBadDest;
      end else begin
        if (som) begin
          committed_length_next = '0;
          saved_ic_next         = type_byte[7];
          saved_type_next       = type_byte[6:0];
          saved_source_next     = hdr_source;
        end
        if (!seq_ok) begin
          res_next.status = mpr_pkg::StBadSeq;
        end else begin
          if (som) begin
            last_seq_next            = seq;
            saved_tag_and_owner_next = hdr_flags[3:0];
          end
          if (total > LenW'(mpr_pkg::MaxMsg)) begin
            res_next.status = mpr_pkg::StOverflow;
          end else begin
            last_seq_next         = seq;
            committed_length_next = total;
            res_next.status       = eom ? mpr_pkg::StComplete : mpr_pkg::StAccepted;
          end
        end
      end
      res_next.msg_kind  = saved_type_next;
      res_next.msg_ic    = saved_ic_next;
      res_next.src_eid   = saved_source_next;
      res_next.msg_tag   = saved_tag_and_owner_next[2:0];
      res_next.tag_owner = saved_tag_and_owner_next[3];
      res_next.msg_len   = committed_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      hdr_dest            <= '0;
      hdr_source          <= '0;
      hdr_flags           <= '0;
      pending_type_byte   <= '0;
      committed_length    <= '0;
      last_seq            <= '0;
      saved_type          <= '0;
      saved_ic            <= 1'b0;
      saved_source        <= '0;
      saved_tag_and_owner <= '0;
    end else if (advance) begin
      byte_position       <= byte_position_next;
      hdr_dest            <= hdr_dest_next;
      hdr_source          <= hdr_source_next;
      hdr_flags           <= hdr_flags_next;
      pending_type_byte   <= pending_type_byte_next;
      committed_length    <= committed_length_next;
      last_seq            <= last_seq_next;
      saved_type          <= saved_type_next;
      saved_ic            <= saved_ic_next;
      saved_source        <= saved_source_next;
      saved_tag_and_owner <= saved_tag_and_owner_next;
    end
  end

  // -------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (advance) begin
      msg_valid <= 1'b1;
    end else if (!msg_stall) begin
      msg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      msg_word <= res_next;
    end
  end

  // ------------------------------------------------------------ assertions
  `MPR_NEVER(a_len_bound, clk, rst,
             committed_length > LenW'(mpr_pkg::MaxMsg),
             "message length beyond buffer")
  `MPR_ASSERT(a_pos_clear, clk, rst,
              advance && stage_word.pkt_last |=> byte_position == 8'd0,
              "position not cleared at packet end")
  `MPR_ASSERT(a_no_commit, clk, rst,
              advance && stage_word.pkt_last &&
              (res_next.status == mpr_pkg::StTooLong ||
               res_next.status == mpr_pkg::StTooSmall ||
               res_next.status == mpr_pkg::StBadDest) |=> $stable(committed_length),
              "rejected packet changed length")
  `MPR_NEVER(a_stall_empty, clk, rst, pkt_stall && !stage_valid,
             "stall with empty input register")

endmodule

`default_nettype wire
